### hw/rtl/ovl_pkg.sv
// shared request and status codes for the ordered value list
package ovl_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned REQ_W    = 2;
    localparam int unsigned STATUS_W = 3;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_ADD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DEL  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LIST = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_ADDED    = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_DELETED  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_LISTED   = 3'd5;

endpackage

### hw/rtl/ordered_value_list_core.sv
// ordered value list: append, delete first match, list all, over one shared entry ram
//
// Keeps up to CAPACITY signed 32-bit values in arrival order in a ram. A request
// transaction carries its kind in s_tuser (0 append, 1 delete first equal value,
// 2 list all, 3 ignored) and its value in s_tdata. Every request other than an
// ignored one answers with result transactions on the master side: status in
// m_tuser, value in m_tdata, m_tlast on the final result of the request. The
// block handles one request at a time and s_tready is low while it works; a
// finished result sits in the output register, so the next request can be taken
// while that result waits. An append writes the ram as it is accepted; delete
// reads the ram one entry a cycle from the head until it finds a match at
// position k, then moves each later entry down one place, one per cycle;
// listing emits one entry per cycle from the ram's read port while the receiver
// takes them. The ram's single read port and single write port set these rates.
// The list is empty after reset; no clearing pass is needed since only entries
// below the fill count are read.
module ordered_value_list_core
    import ovl_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [VALUE_W-1:0]  s_tdata,   // item_value[31:0]
    input  logic [REQ_W-1:0]    s_tuser,   // req_type[1:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [VALUE_W-1:0]  m_tdata,   // out_value[31:0]
    output logic [STATUS_W-1:0] m_tuser,   // status[2:0]
    output logic                m_tlast    // last
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_LIST,
        ST_RESULT
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [VALUE_W-1:0]  val_reg, val_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [VALUE_W-1:0]  res_value_reg, res_value_next;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [VALUE_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0] m_tuser_reg, m_tuser_next;
    logic                m_tlast_reg, m_tlast_next;

    // ram port signals
    logic                ram_wr_en;
    logic [IDX_W-1:0]    ram_wr_addr;
    logic [VALUE_W-1:0]  ram_wr_data;
    logic [IDX_W-1:0]    ram_rd_addr;
    logic [VALUE_W-1:0]  ram_rd_data;

    logic                out_free;
    logic [CNT_W-1:0]    idx_plus1;
    logic [CNT_W-1:0]    idx_plus2;

    ovl_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign m_tlast   = m_tlast_reg;

    // output register can take a new result this cycle
    assign out_free  = !m_tvalid_reg || m_tready;
    assign idx_plus1 = CNT_W'(idx_reg) + CNT_W'(1);
    assign idx_plus2 = CNT_W'(idx_reg) + CNT_W'(2);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        val_next        = val_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        m_tlast_next    = m_tlast_reg;
        // hold the read address so a stalled listing keeps its data
        ram_rd_addr     = idx_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = idx_reg;
        ram_wr_data     = ram_rd_data;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    val_next = s_tdata;
                    unique case (s_tuser)
                        REQ_ADD:
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                res_status_next = STAT_FULL;
                                res_value_next  = '0;
                            end
                            else
                            begin
                                ram_wr_en       = 1'b1;
                                ram_wr_addr     = count_reg[IDX_W-1:0];
                                ram_wr_data     = s_tdata;
                                count_next      = count_reg + CNT_W'(1);
                                res_status_next = STAT_ADDED;
                                res_value_next  = s_tdata;
                            end
                            state_next = ST_RESULT;
                        end
                        REQ_DEL, REQ_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = STAT_EMPTY;
                                res_value_next  = '0;
                                state_next      = ST_RESULT;
                            end
                            else
                            begin
                                // head entry is on the read port next cycle
                                ram_rd_addr = '0;
                                idx_next    = '0;
                                state_next  = (s_tuser == REQ_DEL) ? ST_SCAN : ST_LIST;
                            end
                        end
                        default:
                        begin
                            // unused request kind: dropped without a result
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (ram_rd_data == val_reg)
                begin
                    res_status_next = STAT_DELETED;
                    res_value_next  = val_reg;
                    if (idx_plus1 == count_reg)
                    begin
                        // match at the tail, nothing to move
                        count_next = count_reg - CNT_W'(1);
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        ram_rd_addr = idx_reg + IDX_W'(1);
                        state_next  = ST_SHIFT;
                    end
                end
                else if (idx_plus1 == count_reg)
                begin
                    res_status_next = STAT_NOTFOUND;
                    res_value_next  = '0;
                    state_next      = ST_RESULT;
                end
                else
                begin
                    ram_rd_addr = idx_reg + IDX_W'(1);
                    idx_next    = idx_reg + IDX_W'(1);
                end
            end

            ST_SHIFT:
            begin
                // entry idx+1 is on the read port, move it down to idx
                ram_wr_en   = 1'b1;
                ram_wr_addr = idx_reg;
                ram_wr_data = ram_rd_data;
                if (idx_plus2 == count_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = ST_RESULT;
                end
                else
                begin
                    ram_rd_addr = idx_reg + IDX_W'(2);
                    idx_next    = idx_reg + IDX_W'(1);
                end
            end

            ST_LIST:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = STAT_LISTED;
                    m_tdata_next  = ram_rd_data;
                    m_tlast_next  = (idx_plus1 == count_reg);
                    if (idx_plus1 == count_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ram_rd_addr = idx_reg + IDX_W'(1);
                        idx_next    = idx_reg + IDX_W'(1);
                    end
                end
            end

            ST_RESULT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_status_reg;
                    m_tdata_next  = res_value_reg;
                    m_tlast_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            val_reg        <= '0;
            res_status_reg <= '0;
            res_value_reg  <= '0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
            m_tuser_reg    <= '0;
            m_tlast_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            val_reg        <= val_next;
            res_status_reg <= res_status_next;
            res_value_reg  <= res_value_next;
            m_tvalid_reg   <= m_tvalid_next;
            m_tdata_reg    <= m_tdata_next;
            m_tuser_reg    <= m_tuser_next;
            m_tlast_reg    <= m_tlast_next;
        end
    end

`ifndef SYNTHESIS
    // fill count stays within the ram
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // an accepted append on a list with room grows it by one
    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == REQ_ADD && count_reg != CNT_W'(CAPACITY))
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("append did not grow the list");

    // the move-down pass only touches live entries
    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> (idx_plus2 <= count_reg))
        else $error("shift beyond the list tail");

    // every result other than a listed entry closes its request
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != STAT_LISTED) |-> m_tlast)
        else $error("single result without last");
`endif

endmodule

### hw/rtl/ovl_ram.sv
// generic single write port ram with registered read
module ovl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### sim/ordered_value_list_core_tb.sv
// testbench for the ordered value list core: directed and random requests against a predictor
module ordered_value_list_core_tb;
    import ovl_pkg::*;

    localparam int LIST_CAPACITY = 16;
    // request code that the block must ignore
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    // cycles allowed after the last result before the verdict
    localparam int SETTLE_CYCLES = 4 * LIST_CAPACITY + 8;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  value;
        logic                last;
    } list_result_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [VALUE_W-1:0]  s_tdata;   // item_value[31:0]
    logic [REQ_W-1:0]    s_tuser;   // req_type[1:0]
    logic                m_tvalid;
    logic                m_tready;
    logic [VALUE_W-1:0]  m_tdata;   // out_value[31:0]
    logic [STATUS_W-1:0] m_tuser;   // status[2:0]
    logic                m_tlast;

    // shadow copy of the list, head at index 0
    logic [VALUE_W-1:0] shadow_list[$];
    // results still owed by the block, oldest first
    list_result_t       awaited_results[$];
    int                 mismatch_count;
    bit                 idle_on;

    ordered_value_list_core #(
        .CAPACITY (LIST_CAPACITY)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // update the shadow list and queue the results one accepted request owes
    function automatic void predict_list_request(logic [REQ_W-1:0] kind,
                                                 logic [VALUE_W-1:0] value);
        int hit;
        hit = -1;
        case (kind)
            REQ_ADD:
            begin
                if (shadow_list.size() >= LIST_CAPACITY)
                    awaited_results.push_back('{STAT_FULL, '0, 1'b1});
                else
                begin
                    shadow_list.push_back(value);
                    awaited_results.push_back('{STAT_ADDED, value, 1'b1});
                end
            end
            REQ_DEL:
            begin
                if (shadow_list.size() == 0)
                    awaited_results.push_back('{STAT_EMPTY, '0, 1'b1});
                else
                begin
                    // first match from the head wins
                    for (int i = 0; i < shadow_list.size(); i++)
                        if (hit < 0 && shadow_list[i] == value)
                            hit = i;
                    if (hit < 0)
                        awaited_results.push_back('{STAT_NOTFOUND, '0, 1'b1});
                    else
                    begin
                        shadow_list.delete(hit);
                        awaited_results.push_back('{STAT_DELETED, value, 1'b1});
                    end
                end
            end
            REQ_LIST:
            begin
                if (shadow_list.size() == 0)
                    awaited_results.push_back('{STAT_EMPTY, '0, 1'b1});
                else
                    for (int i = 0; i < shadow_list.size(); i++)
                        awaited_results.push_back('{STAT_LISTED, shadow_list[i],
                                                    i == shadow_list.size() - 1});
            end
            default: ;  // unused code leaves everything as it was
        endcase
    endfunction

    // one request transaction; valid stays high afterwards so back-to-back requests
    // never lower and raise it in the same step
    task automatic send_request(input logic [REQ_W-1:0] kind, input logic [VALUE_W-1:0] value);
        if (idle_on && $urandom_range(99) < 30)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= kind;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_list_request(kind, value);
    endtask

    // sender goes quiet until every owed result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // mix of wide random values, a small pool that forces duplicates, corner values and held entries
    function automatic logic [VALUE_W-1:0] pick_value(bit favor_held);
        int roll;
        roll = $urandom_range(9);
        if (shadow_list.size() != 0 && (roll >= 7 || (favor_held && roll >= 3)))
            return shadow_list[$urandom_range(shadow_list.size() - 1)];
        if (roll < 3)
            return $urandom();
        if (roll < 5)
            return VALUE_W'($urandom_range(7));
        case ($urandom_range(3))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            default: return 32'h0000_0000;
        endcase
    endfunction

    task automatic test_empty_cases();
        send_request(REQ_LIST, 32'h1234_5678);   // list on empty list
        send_request(REQ_DEL, 32'h0000_0000);    // delete on empty list
        send_request(REQ_UNUSED, 32'hffff_ffff); // ignored request
        send_request(REQ_ADD, 32'hc0de_0001);
        send_request(REQ_DEL, 32'hc0de_0001);    // delete of the only entry
        send_request(REQ_LIST, 32'h0000_0000);   // list must be empty again
    endtask

    task automatic test_fill_to_capacity();
        logic [VALUE_W-1:0] fill_values[LIST_CAPACITY] = '{
            32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
            32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001, 32'h0000_0007,
            32'h1234_5678, 32'h0000_0000, 32'hdead_beef, 32'h8000_0001,
            32'h7fff_fffe, 32'h0000_0001, 32'hffff_fffe, 32'h0f0f_0f0f};
        foreach (fill_values[i])
            send_request(REQ_ADD, fill_values[i]);
        send_request(REQ_ADD, 32'h2222_2222);    // append when full
    endtask

    task automatic test_delete_positions();
        send_request(REQ_DEL, 32'h0000_0003);    // no match
        send_request(REQ_DEL, 32'h8000_0000);    // head entry
        send_request(REQ_DEL, 32'h0f0f_0f0f);    // tail entry
        send_request(REQ_DEL, 32'h0000_0000);    // first of two equal entries
        drain_results();                         // sender holds off until all results are in
        send_request(REQ_LIST, 32'h0000_0000);
    endtask

    // count requests (ignored ones excluded) with the given add and delete shares
    task automatic random_phase(input int count, input int add_pct, input int del_pct);
        int taken;
        int roll;
        taken = 0;
        while (taken < count)
        begin
            roll = $urandom_range(99);
            if (roll < add_pct)
                send_request(REQ_ADD, pick_value(1'b0));
            else if (roll < add_pct + del_pct)
                send_request(REQ_DEL, pick_value(1'b1));
            else if (roll < 96)
                send_request(REQ_LIST, $urandom());
            else
            begin
                send_request(REQ_UNUSED, $urandom());
                taken--;
            end
            taken++;
        end
    endtask

    task automatic test_random_traffic();
        random_phase(90, 65, 20);     // mostly appends, runs into full often
        random_phase(80, 25, 60);     // mostly deletes, drains to empty
        idle_on = 1'b0;               // long stretch at full rate on both sides
        random_phase(90, 45, 40);
        idle_on = 1'b1;
        drain_results();
        random_phase(100, 45, 40);
    endtask

    // result checker: compare each result transaction with the oldest owed one
    always @(posedge clk)
    begin : check_result
        list_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: status %0d value %h last %0b",
                             m_tuser, m_tdata, m_tlast);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (m_tuser !== want.status || m_tdata !== want.value
                    || m_tlast !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch: expected status %0d value %h last %0b, got status %0d value %h last %0b",
                                 want.status, want.value, want.last,
                                 m_tuser, m_tdata, m_tlast);
                end
            end
        end
    end

    // receiver stalls at random while idling is on
    always @(posedge clk)
        m_tready <= !idle_on || ($urandom_range(99) >= 30);

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        m_tready       = 1'b0;
        mismatch_count = 0;
        idle_on        = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_cases();
        test_fill_to_capacity();
        test_delete_positions();
        test_random_traffic();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        mismatch_count += awaited_results.size();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog for a hung handshake
    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/ovl_pkg.sv
hw/rtl/ovl_ram.sv
hw/rtl/ordered_value_list_core.sv
sim/ordered_value_list_core_tb.sv
